// ----- hw/rtl/integer_token_parser_defines.svh -----
// Assertion macros for the integer token parser checker.
`ifndef INTEGER_TOKEN_PARSER_DEFINES_SVH
`define INTEGER_TOKEN_PARSER_DEFINES_SVH

// Checked at every edge outside reset.
`define ITP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every edge, reset included.
`define ITP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hw/rtl/itp_pkg.sv -----
// Types and constants of the integer token parser.
`default_nettype none
package itp_pkg;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_F  = 8'h46;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_F  = 8'h66;
  localparam logic [7:0] CH_LO_X  = 8'h78;

  localparam logic [3:0] MAX_DEC_DIGITS = 4'd9;
  localparam logic [3:0] MAX_HEX_DIGITS = 4'd8;
  localparam logic [3:0] COUNT_MAX      = 4'd15;

  // Character class as seen by the front part; mode independent.
  typedef struct packed {
    logic       dec_digit;
    logic       hex_digit;
    logic [3:0] dval;
    logic       sign;
    logic       minus;
    logic       lower_x;
    logic       zero_char;
    logic       nul;
    logic       space;
  } cls_t;

  typedef struct packed {
    logic [31:0] value;
    logic        valid_res;
    logic        ended_on_space;
  } res_t;

  typedef enum logic [1:0] {
    PH_START = 2'b01,
    PH_BODY  = 2'b10
  } phase_t;

endpackage
`default_nettype wire

// ----- hw/rtl/integer_token_parser.sv -----
// A character is classified on entry and reaches the back part through the character queue;
// a result enters the result queue when its ending character is taken and shows on the result ports from its head.
// Throughput: one character per cycle, set by the shift-add in the back part,
// as long as results are drained; the two queues absorb short stalls on either side.
// Reset (rst, synchronous): both queues empty, token state at start, stored mode cleared.
// A configuration transfer restarts the current token without giving a result.
`default_nettype none
module integer_token_parser #(
  parameter int unsigned CLS_DEPTH = 2,
  parameter int unsigned RES_DEPTH = 2
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         push,
  output logic        full,
  input  wire  [7:0]  char_in,
  output logic        empty,
  input  wire         pop,
  output logic [31:0] value,
  output logic        valid_res,
  output logic        ended_on_space,
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire         hex_mode
);

  logic           mode;
  logic           cfg_write;
  itp_pkg::cls_t  cls_in;
  itp_pkg::cls_t  cls_head;
  logic           cls_empty;
  logic           cls_take;
  logic           res_full;
  logic           res_valid;
  itp_pkg::res_t  res_in;
  itp_pkg::res_t  res_head;

  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= 1'b0;
    end else if (cfg_write) begin
      mode <= hex_mode;
    end
  end

  itp_front u_front (
    .char_in (char_in),
    .cls     (cls_in)
  );

  itp_fifo #(
    .T     (itp_pkg::cls_t),
    .DEPTH (CLS_DEPTH)
  ) u_cls_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (push),
    .wr_data (cls_in),
    .rd_en   (cls_take),
    .rd_data (cls_head),
    .full    (full),
    .empty   (cls_empty)
  );

  itp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .hex_mode  (mode),
    .restart   (cfg_write),
    .in_valid  (!cls_empty),
    .cls       (cls_head),
    .out_room  (!res_full),
    .in_take   (cls_take),
    .res_valid (res_valid),
    .res       (res_in)
  );

  itp_fifo #(
    .T     (itp_pkg::res_t),
    .DEPTH (RES_DEPTH)
  ) u_res_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (res_valid),
    .wr_data (res_in),
    .rd_en   (pop),
    .rd_data (res_head),
    .full    (res_full),
    .empty   (empty)
  );

  assign value          = res_head.value;
  assign valid_res      = res_head.valid_res;
  assign ended_on_space = res_head.ended_on_space;

endmodule
`default_nettype wire

// ----- hw/rtl/itp_fifo.sv -----
// Small first-in first-out queue in flip-flops.
`default_nettype none
module itp_fifo #(
  parameter type T = logic,
  parameter int unsigned DEPTH = 2
) (
  input  wire  clk,
  input  wire  rst,
  input  wire  wr_en,
  input  T     wr_data,
  input  wire  rd_en,
  output T     rd_data,
  output logic full,
  output logic empty
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

  T              mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  logic do_wr;
  logic do_rd;

  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign full    = (count == FULL_COUNT);
  assign empty   = (count == '0);
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + PW'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + PW'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + CW'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/itp_front.sv -----
// Front part: classifies each incoming character.
`default_nettype none
module itp_front (
  input  wire  [7:0]      char_in,
  output itp_pkg::cls_t   cls
);

  logic is_dec;
  logic is_up;
  logic is_lo;

  always_comb begin
    is_dec = (char_in >= itp_pkg::CH_ZERO) && (char_in <= itp_pkg::CH_NINE);
    is_up  = (char_in >= itp_pkg::CH_UP_A) && (char_in <= itp_pkg::CH_UP_F);
    is_lo  = (char_in >= itp_pkg::CH_LO_A) && (char_in <= itp_pkg::CH_LO_F);

    cls.dec_digit = is_dec;
    cls.hex_digit = is_dec || is_up || is_lo;
    // Letters A-F and a-f have low nibbles 1 to 6, so adding nine gives 10 to 15.
    cls.dval      = is_dec ? char_in[3:0] : (char_in[3:0] + 4'd9);
    cls.sign      = (char_in == itp_pkg::CH_PLUS) || (char_in == itp_pkg::CH_MINUS);
    cls.minus     = (char_in == itp_pkg::CH_MINUS);
    cls.lower_x   = (char_in == itp_pkg::CH_LO_X);
    cls.zero_char = (char_in == itp_pkg::CH_ZERO);
    cls.nul       = (char_in == itp_pkg::CH_NUL);
    cls.space     = (char_in == itp_pkg::CH_SPACE);
  end

endmodule
`default_nettype wire

// ----- hw/rtl/itp_back.sv -----
// Back part: token state, digit accumulation and result forming.
`default_nettype none
module itp_back (
  input  wire            clk,
  input  wire            rst,
  input  wire            hex_mode,
  input  wire            restart,
  input  wire            in_valid,
  input  itp_pkg::cls_t  cls,
  input  wire            out_room,
  output logic           in_take,
  output logic           res_valid,
  output itp_pkg::res_t  res
);

  itp_pkg::phase_t phase, phase_next;
  logic [31:0] acc, acc_next;
  logic [3:0]  count, count_next;
  logic        negative, negative_next;
  logic        first_zero, first_zero_next;

  logic [31:0] acc_dec;
  logic [31:0] acc_hex;
  logic [3:0]  count_inc;
  logic [3:0]  limit;
  logic        ok;
  logic        ending;
  logic [31:0] signed_val;

  assign in_take = in_valid && out_room;

  always_comb begin
    acc_dec    = (acc << 3) + (acc << 1) + {28'd0, cls.dval};
    acc_hex    = {acc[27:0], cls.dval};
    count_inc  = (count == itp_pkg::COUNT_MAX) ? count : count + 4'd1;
    limit      = hex_mode ? itp_pkg::MAX_HEX_DIGITS : itp_pkg::MAX_DEC_DIGITS;
    signed_val = negative ? (32'd0 - acc) : acc;

    phase_next      = phase;
    acc_next        = acc;
    count_next      = count;
    negative_next   = negative;
    first_zero_next = first_zero;
    ending          = 1'b0;

    if (!hex_mode) begin
      if ((phase == itp_pkg::PH_START) && cls.sign) begin
        negative_next = cls.minus;
        phase_next    = itp_pkg::PH_BODY;
      end else if (cls.dec_digit) begin
        acc_next   = acc_dec;
        count_next = count_inc;
        phase_next = itp_pkg::PH_BODY;
      end else begin
        ending = 1'b1;
      end
    end else begin
      if (first_zero && cls.lower_x) begin
        // The leading zero was a prefix after all; drop it.
        acc_next        = '0;
        count_next      = '0;
        first_zero_next = 1'b0;
        phase_next      = itp_pkg::PH_BODY;
      end else if (cls.hex_digit) begin
        first_zero_next = (phase == itp_pkg::PH_START) && cls.zero_char;
        acc_next        = acc_hex;
        count_next      = count_inc;
        phase_next      = itp_pkg::PH_BODY;
      end else begin
        ending = 1'b1;
      end
    end

    ok = (count != 4'd0) && (count <= limit) && (cls.nul || cls.space);
    res.value          = ok ? signed_val : 32'd0;
    res.valid_res      = ok;
    res.ended_on_space = cls.space;
    res_valid          = in_take && ending;

    if (ending) begin
      phase_next      = itp_pkg::PH_START;
      acc_next        = '0;
      count_next      = '0;
      negative_next   = 1'b0;
      first_zero_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      phase      <= itp_pkg::PH_START;
      acc        <= '0;
      count      <= '0;
      negative   <= 1'b0;
      first_zero <= 1'b0;
    end else if (in_take) begin
      phase      <= phase_next;
      acc        <= acc_next;
      count      <= count_next;
      negative   <= negative_next;
      first_zero <= first_zero_next;
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/itp_checker.sv -----
// Port-level checks of the integer token parser, bound to the top level.
`default_nettype none
`include "integer_token_parser_defines.svh"
module itp_checker (
  input wire        clk,
  input wire        rst,
  input wire        full,
  input wire        empty,
  input wire        pop,
  input wire [31:0] value,
  input wire        valid_res
);

  `ITP_ASSERT_ALWAYS(a_reset_clears, rst |=> (empty && !full), "queues not empty after reset")
  `ITP_ASSERT(a_invalid_zero, (!empty && !valid_res) |-> (value == 32'd0), "invalid result has nonzero value")
  `ITP_ASSERT(a_result_holds, (!empty && !pop) |=> (!empty && $stable(value) && $stable(valid_res)), "waiting result changed")

endmodule

bind integer_token_parser itp_checker u_itp_checker (.*);
`default_nettype wire
